### hdl/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
// Used by every module under hdl; depends on nothing.
package bpc_pkg;

	localparam int unsigned COEF_W = 16;
	localparam int unsigned RAW_W  = 24;
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned PRES_W = 32;
	localparam int unsigned IDX_W  = 3;

	// Temperature thresholds in 0.01 C
	localparam logic signed [19:0] TEMP_REF = 20'sd2000;
	localparam logic signed [19:0] TEMP_LOW = -20'sd1500;

	localparam logic signed [PRES_W-1:0] PRES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [PRES_W-1:0] PRES_MIN = 32'sh8000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] c3;
		logic [COEF_W-1:0] c4;
		logic [COEF_W-1:0] c5;
		logic [COEF_W-1:0] c6;
	} coef_t;

	// First-order results
	typedef struct packed {
		logic               valid;
		logic signed [19:0] temp;
		logic signed [35:0] off;
		logic signed [34:0] sens;
		logic [16:0]        t2;
		logic [RAW_W-1:0]   d1;
	} first_t;

	// Corrected temperature, offset and sensitivity
	typedef struct packed {
		logic               valid;
		logic signed [19:0] temp;
		logic signed [40:0] off;
		logic signed [40:0] sens;
		logic [RAW_W-1:0]   d1;
	} second_t;

endpackage

### hdl/bpc_cfg_regs.sv
// Calibration word registers written through the plain write port.
// Depends on bpc_pkg.
module bpc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bpc_pkg::COEF_W-1:0]  cfg_data,
	output bpc_pkg::coef_t              coef
);
	import bpc_pkg::*;

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_C1: coef_q.c1 <= cfg_data;
				REG_C2: coef_q.c2 <= cfg_data;
				REG_C3: coef_q.c3 <= cfg_data;
				REG_C4: coef_q.c4 <= cfg_data;
				REG_C5: coef_q.c5 <= cfg_data;
				REG_C6: coef_q.c6 <= cfg_data;
				default: ; // drop writes beyond the last register
			endcase
		end
	end

	assign coef = coef_q;

endmodule

### hdl/bpc_first_order.sv
// Stages 1 to 3: temperature difference, coefficient products and
// first-order temperature, offset and sensitivity. Depends on bpc_pkg.
module bpc_first_order (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [bpc_pkg::RAW_W-1:0]   pressure_raw,
	input  logic [bpc_pkg::RAW_W-1:0]   temp_raw,
	input  bpc_pkg::coef_t              coef,
	output bpc_pkg::first_t             fo
);
	import bpc_pkg::*;

	logic                v_s1, v_s2, v_s3;
	logic [RAW_W-1:0]    d1_s1, d1_s2, d1_s3;
	logic signed [24:0]  dt_s1;
	logic signed [24:0]  dt_next;
	logic signed [41:0]  tc_s2, offp_s2, snp_s2;
	logic signed [49:0]  sq_s2;
	logic signed [19:0]  temp_s3, temp_next;
	logic signed [35:0]  off_s3, off_next;
	logic signed [34:0]  sens_s3, sens_next;
	logic [16:0]         t2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		dt_next   = $signed({1'b0, temp_raw}) - $signed({1'b0, coef.c5, 8'h00});
		temp_next = 20'($signed(tc_s2[41:23])) + TEMP_REF;
		off_next  = $signed({4'b0, coef.c2, 16'h0000}) + 36'($signed(offp_s2[41:7]));
		sens_next = $signed({4'b0, coef.c1, 15'h0000}) + 35'($signed(snp_s2[41:8]));
	end

	always_ff @(posedge clk) begin
		d1_s1   <= pressure_raw;
		dt_s1   <= dt_next;

		d1_s2   <= d1_s1;
		tc_s2   <= dt_s1 * $signed({1'b0, coef.c6});
		offp_s2 <= dt_s1 * $signed({1'b0, coef.c4});
		snp_s2  <= dt_s1 * $signed({1'b0, coef.c3});
		sq_s2   <= dt_s1 * dt_s1;

		d1_s3   <= d1_s2;
		temp_s3 <= temp_next;
		off_s3  <= off_next;
		sens_s3 <= sens_next;
		// square is never negative, so the floor is a plain bit select
		t2_s3   <= sq_s2[47:31];
	end

	always_comb begin
		fo.valid = v_s3;
		fo.temp  = temp_s3;
		fo.off   = off_s3;
		fo.sens  = sens_s3;
		fo.t2    = t2_s3;
		fo.d1    = d1_s3;
	end

endmodule

### hdl/bpc_second_order.sv
// Stages 4 to 6: low-temperature correction of temperature, offset and
// sensitivity. Depends on bpc_pkg.
module bpc_second_order (
	input  logic              clk,
	input  logic              arst_n,
	input  bpc_pkg::first_t   fo,
	output bpc_pkg::second_t  so
);
	import bpc_pkg::*;

	logic                v_s4, v_s5, v_s6;
	logic signed [19:0]  t_c, u_c;
	logic signed [39:0]  tt_full, uu_full;
	logic [34:0]         tt_s4, uu_s4;
	logic                lt_ref_s4, lt_low_s4;
	logic signed [19:0]  temp_s4, temp_s5, temp_s6;
	logic signed [35:0]  off_s4, off_s5;
	logic signed [34:0]  sens_s4, sens_s5;
	logic [16:0]         t2_s4;
	logic [RAW_W-1:0]    d1_s4, d1_s5, d1_s6;
	logic [37:0]         five_tt;
	logic [37:0]         seven_uu;
	logic [38:0]         eleven_uu;
	logic [38:0]         off2_next, sens2_next, off2_s5, sens2_s5;
	logic signed [19:0]  temp_next;
	logic signed [40:0]  off_s6, sens_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= fo.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		t_c     = fo.temp - TEMP_REF;
		u_c     = fo.temp - TEMP_LOW;
		tt_full = t_c * t_c;
		uu_full = u_c * u_c;

		five_tt   = {1'b0, tt_s4, 2'b00} + {3'b000, tt_s4};
		seven_uu  = {uu_s4, 3'b000} - {3'b000, uu_s4};
		eleven_uu = {1'b0, uu_s4, 3'b000} + {3'b000, uu_s4, 1'b0} + {4'b0000, uu_s4};

		off2_next  = '0;
		sens2_next = '0;
		temp_next  = temp_s4;
		if (lt_ref_s4) begin
			off2_next  = {2'b00, five_tt[37:1]};
			sens2_next = {3'b000, five_tt[37:2]};
			temp_next  = temp_s4 - $signed({3'b000, t2_s4});
			// extra term below the low threshold
			if (lt_low_s4) begin
				off2_next  = off2_next + {1'b0, seven_uu};
				sens2_next = sens2_next + {1'b0, eleven_uu[38:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		tt_s4     <= tt_full[34:0];
		uu_s4     <= uu_full[34:0];
		lt_ref_s4 <= fo.temp < TEMP_REF;
		lt_low_s4 <= fo.temp < TEMP_LOW;
		temp_s4   <= fo.temp;
		off_s4    <= fo.off;
		sens_s4   <= fo.sens;
		t2_s4     <= fo.t2;
		d1_s4     <= fo.d1;

		off2_s5   <= off2_next;
		sens2_s5  <= sens2_next;
		temp_s5   <= temp_next;
		off_s5    <= off_s4;
		sens_s5   <= sens_s4;
		d1_s5     <= d1_s4;

		off_s6    <= 41'(off_s5) - $signed({2'b00, off2_s5});
		sens_s6   <= 41'(sens_s5) - $signed({2'b00, sens2_s5});
		temp_s6   <= temp_s5;
		d1_s6     <= d1_s5;
	end

	always_comb begin
		so.valid = v_s6;
		so.temp  = temp_s6;
		so.off   = off_s6;
		so.sens  = sens_s6;
		so.d1    = d1_s6;
	end

endmodule

### hdl/bpc_pressure.sv
// Stages 7 to 9: raw pressure times sensitivity in two partial products,
// offset removal, scaling and saturation. Depends on bpc_pkg.
module bpc_pressure (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bpc_pkg::second_t                   so,
	output logic                               done,
	output logic signed [bpc_pkg::TEMP_W-1:0]  temperature_centi,
	output logic signed [bpc_pkg::PRES_W-1:0]  pressure_centi
);
	import bpc_pkg::*;

	logic                v_s7, v_s8, v_s9;
	logic [44:0]         lo_s7;
	logic signed [44:0]  hi_s7;
	logic signed [40:0]  off_s7, off_s8;
	logic signed [19:0]  temp_s7, temp_s8;
	logic signed [45:0]  sh_s8;
	logic signed [47:0]  diff;
	logic [32:0]         pf;
	logic signed [PRES_W-1:0] pres_next, pres_s9;
	logic signed [TEMP_W-1:0] temp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s7 <= so.valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_comb begin
		diff = 48'(sh_s8) - 48'(off_s8);
		pf   = diff[47:15];
		// clamp when the scaled value leaves the signed 32-bit range
		if (pf[32] != pf[31])
			pres_next = pf[32] ? PRES_MIN : PRES_MAX;
		else
			pres_next = $signed(pf[31:0]);
	end

	always_ff @(posedge clk) begin
		lo_s7   <= so.d1 * so.sens[20:0];
		hi_s7   <= $signed({1'b0, so.d1}) * $signed(so.sens[40:21]);
		off_s7  <= so.off;
		temp_s7 <= so.temp;

		// floor of the full product over 2^21: high part plus carried low bits
		sh_s8   <= 46'(hi_s7) + $signed({22'b0, lo_s7[44:21]});
		off_s8  <= off_s7;
		temp_s8 <= temp_s7;

		pres_s9 <= pres_next;
		temp_s9 <= temp_s8[TEMP_W-1:0];
	end

	assign done              = v_s9;
	assign temperature_centi = temp_s9;
	assign pressure_centi    = pres_s9;

endmodule

### hdl/baro_pressure_temp_compensation_unit.sv
// Barometric pressure and temperature compensation, nine-stage pipeline.
// done and both results are driven from registers of the last stage.
// Throughput: one item per cycle; busy stays low and results cannot be held off.
// Reset clears the valid bits and the calibration words to zero.
// Depends on bpc_pkg, bpc_cfg_regs, bpc_first_order, bpc_second_order, bpc_pressure.
module baro_pressure_temp_compensation_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [bpc_pkg::RAW_W-1:0]          pressure_raw,
	input  logic [bpc_pkg::RAW_W-1:0]          temp_raw,
	input  logic                               cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bpc_pkg::COEF_W-1:0]         cfg_data,
	output logic                               done,
	output logic signed [bpc_pkg::TEMP_W-1:0]  temperature_centi,
	output logic signed [bpc_pkg::PRES_W-1:0]  pressure_centi
);
	import bpc_pkg::*;

	coef_t   coef;
	first_t  fo;
	second_t so;

	assign busy = 1'b0;

	bpc_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bpc_first_order u_first (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.pressure_raw (pressure_raw),
		.temp_raw     (temp_raw),
		.coef         (coef),
		.fo           (fo)
	);

	bpc_second_order u_second (
		.clk    (clk),
		.arst_n (arst_n),
		.fo     (fo),
		.so     (so)
	);

	bpc_pressure u_pres (
		.clk               (clk),
		.arst_n            (arst_n),
		.so                (so),
		.done              (done),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi)
	);

endmodule

### sim/bpc_reading_checker.sv
`timescale 1ns / 100ps
// Checker for the barometric compensation unit: mirrors the calibration words,
// predicts each compensated reading and compares it with the block's results.
// Depends on bpc_pkg for widths, register indexes and thresholds.
module bpc_reading_checker
	import bpc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [RAW_W-1:0]           pressure_raw,
	input  logic [RAW_W-1:0]           temp_raw,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]          cfg_data,
	input  logic                       done,
	input  logic signed [TEMP_W-1:0]   temperature_centi,
	input  logic signed [PRES_W-1:0]   pressure_centi,
	output int                         fail_count,
	output int                         pending
);

	localparam longint T_REF  = TEMP_REF;
	localparam longint T_LOW  = TEMP_LOW;
	localparam longint P_HIGH = PRES_MAX;
	localparam longint P_LOW  = PRES_MIN;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PRES_W-1:0] pres;
	} reading_t;

	logic [COEF_W-1:0] coef_c1, coef_c2, coef_c3, coef_c4, coef_c5, coef_c6;
	reading_t          expected_readings[$];

	// All divisions by powers of two floor, so arithmetic shifts on longint do.
	function automatic reading_t compensate(input logic [RAW_W-1:0] d1r, input logic [RAW_W-1:0] d2r);
		reading_t r;
		longint   dt, tmp, off, sens, t2, off2, sens2, dlt, ulo, pr;
		dt   = longint'(d2r) - (longint'(coef_c5) <<< 8);
		tmp  = T_REF + ((dt * longint'(coef_c6)) >>> 23);
		off  = (longint'(coef_c2) <<< 16) + ((longint'(coef_c4) * dt) >>> 7);
		sens = (longint'(coef_c1) <<< 15) + ((longint'(coef_c3) * dt) >>> 8);
		t2    = 0;
		off2  = 0;
		sens2 = 0;
		if (tmp < T_REF) begin
			dlt   = tmp - T_REF;
			t2    = (dt * dt) >>> 31;
			off2  = (5 * dlt * dlt) >>> 1;
			sens2 = (5 * dlt * dlt) >>> 2;
			if (tmp < T_LOW) begin
				ulo   = tmp - T_LOW;
				off2  = off2 + 7 * ulo * ulo;
				sens2 = sens2 + ((11 * ulo * ulo) >>> 1);
			end
		end
		// thresholds above use the temperature before the second-order term
		tmp = tmp - t2;
		pr  = (((longint'(d1r) * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
		if (pr > P_HIGH)
			pr = P_HIGH;
		if (pr < P_LOW)
			pr = P_LOW;
		r.temp = tmp[TEMP_W-1:0];
		r.pres = pr[PRES_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			coef_c1    <= '0;
			coef_c2    <= '0;
			coef_c3    <= '0;
			coef_c4    <= '0;
			coef_c5    <= '0;
			coef_c6    <= '0;
			fail_count = 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_C1: coef_c1 <= cfg_data;
					REG_C2: coef_c2 <= cfg_data;
					REG_C3: coef_c3 <= cfg_data;
					REG_C4: coef_c4 <= cfg_data;
					REG_C5: coef_c5 <= cfg_data;
					REG_C6: coef_c6 <= cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_readings.push_back(compensate(pressure_raw, temp_raw));
			if (done) begin
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result with no item pending: temp %0d pres %0d",
						temperature_centi, pressure_centi));
				end else begin
					want = expected_readings.pop_front();
					if (temperature_centi !== want.temp)
						report_mismatch($sformatf("temperature_centi got %0d expected %0d",
							temperature_centi, want.temp));
					if (pressure_centi !== want.pres)
						report_mismatch($sformatf("pressure_centi got %0d expected %0d",
							pressure_centi, want.pres));
				end
			end
			pending <= expected_readings.size();
		end
	end

endmodule

### sim/baro_pressure_temp_compensation_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the barometric compensation unit: drives calibration and
// conversion pairs and gives the verdict. Depends on bpc_pkg and bpc_reading_checker.
module baro_pressure_temp_compensation_unit_tb;
	import bpc_pkg::*;

	localparam logic [COEF_W-1:0] COEF_MAX = '1;
	localparam logic [RAW_W-1:0]  RAW_MAX  = '1;
	localparam logic [IDX_W-1:0]  IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0]  IDX_SPARE_HI = 3'd7;
	localparam int                DRAIN_CYCLES = 12;
	localparam int                BLOCKS = 4;
	localparam int                BLOCK_ITEMS = 50;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [RAW_W-1:0]          pressure_raw;
	logic [RAW_W-1:0]          temp_raw;
	logic                      cfg_we;
	logic [IDX_W-1:0]          cfg_index;
	logic [COEF_W-1:0]         cfg_data;
	logic                      done;
	logic signed [TEMP_W-1:0]  temperature_centi;
	logic signed [PRES_W-1:0]  pressure_centi;
	int                        fail_count;
	int                        pending;

	int                        idle_pct;
	logic [COEF_W-1:0]         cur_c5;

	baro_pressure_temp_compensation_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.pressure_raw      (pressure_raw),
		.temp_raw          (temp_raw),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.done              (done),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi)
	);

	bpc_reading_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.pressure_raw      (pressure_raw),
		.temp_raw          (temp_raw),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.done              (done),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(64'd5_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		pressure_raw <= p;
		temp_raw     <= t;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Hold off new items until every pending reading has come out.
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Block must be idle; a junk write to an unused index rides along each time.
	task automatic load_coefs(input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
		input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4,
		input logic [COEF_W-1:0] c5, input logic [COEF_W-1:0] c6);
		write_reg(REG_C1, c1);
		write_reg(REG_C2, c2);
		write_reg(REG_C3, c3);
		write_reg(REG_C4, c4);
		write_reg(REG_C5, c5);
		write_reg(REG_C6, c6);
		write_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, COEF_W'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_c5 = c5;
	endtask

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(3))
			0: return '0;
			1: return COEF_MAX;
			default: return COEF_W'($urandom_range(COEF_MAX));
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] rand_raw_edge();
		case ($urandom_range(2))
			0: return '0;
			1: return RAW_MAX;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// Half of the temperatures land near the reference point so both thresholds get hit.
	task automatic send_random_item();
		longint tl;
		longint span;
		case ($urandom_range(9))
			0: send_item(rand_raw_edge(), rand_raw_edge());
			1, 2, 3, 4: send_item(RAW_W'($urandom), RAW_W'($urandom));
			default: begin
				span = longint'(1) << $urandom_range(23);
				tl   = (longint'(cur_c5) << 8) + longint'($urandom_range(span)) - span / 2;
				if (tl < 0)
					tl = 0;
				if (tl > longint'(RAW_MAX))
					tl = longint'(RAW_MAX);
				send_item(RAW_W'($urandom), tl[RAW_W-1:0]);
			end
		endcase
	endtask

	initial begin
		int phase_pct[3];
		int pause_at;
		phase_pct[0] = 17;
		phase_pct[1] = 48;
		phase_pct[2] = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		pressure_raw = '0;
		temp_raw     = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		idle_pct     = 0;
		cur_c5       = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// calibration words still at reset
		send_item('0, '0);
		send_item(RAW_MAX, RAW_MAX);
		drain_results();

		// typical calibration: around 20 C, exact reference, one step below, cold
		load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
		send_item(24'd9085466, 24'd8569150);
		send_item(24'd9085466, 24'd8566784);
		send_item(24'd9085466, 24'd8566783);
		send_item(24'd9085466, 24'd7529718);
		send_item(24'd9085466, 24'd7529717);
		send_item('0, '0);
		send_item(RAW_MAX, RAW_MAX);
		send_item(RAW_MAX, '0);
		drain_results();

		// every word at its maximum: hottest and coldest corners
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_item(RAW_MAX, '0);
		send_item(RAW_MAX, RAW_MAX);
		send_item('0, '0);
		send_item('0, RAW_MAX);
		send_item(RAW_MAX, {COEF_MAX, 8'd0});
		drain_results();

		// large offsets and sensitivity swings with zero base words
		load_coefs('0, '0, COEF_MAX, COEF_MAX, '0, COEF_MAX);
		send_item(RAW_MAX, RAW_MAX);
		send_item(24'd1, 24'd123456);
		drain_results();
		load_coefs('0, COEF_MAX, '0, COEF_MAX, COEF_MAX, COEF_MAX);
		send_item(RAW_MAX, '0);
		send_item('0, '0);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = phase_pct[ph];
			for (int b = 0; b < BLOCKS; b++) begin
				drain_results();
				load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), rand_coef());
				pause_at = $urandom_range(BLOCK_ITEMS - 1);
				for (int i = 0; i < BLOCK_ITEMS; i++) begin
					if (i == pause_at)
						drain_results();
					send_random_item();
				end
			end
		end

		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
